// ----- sv/sfr_pkg.sv -----
`timescale 1ns / 1ps

package sfr_pkg;

    // Frame store depth
    localparam int PAYLOAD_MAX = 32;

    // Widths; the index, length and count widths derive from the store depth
    localparam int CFG_W = 6;
    localparam int IDX_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
    localparam int LEN_W = $clog2(PAYLOAD_MAX + 1);
    localparam int CNT_W = $clog2(PAYLOAD_MAX + 2);

    // Command queue geometry
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // Frame delimiters
    localparam logic [7:0] HEADER_BYTE = 8'hA5;
    localparam logic [7:0] TAIL_BYTE   = 8'h5A;

    // Result status codes
    localparam logic ST_PAYLOAD = 1'b0;
    localparam logic ST_REJECT  = 1'b1;

    localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(4);

    // Closed frame handed from parser to replay
    typedef struct packed {
        logic             reject;
        logic [LEN_W-1:0] len;
    } cmd_t;

    // Replay engine status seen by the parser
    typedef struct packed {
        logic busy;
    } back_stat_t;

    // Zero reads as one, anything above the store depth saturates
    function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] cfg);
        logic [LEN_W-1:0] n;
        n = LEN_W'(cfg);
        if (cfg == '0)
        begin
            n = LEN_W'(1);
        end
        else if (32'(cfg) > 32'(PAYLOAD_MAX))
        begin
            n = LEN_W'(PAYLOAD_MAX);
        end
        return n;
    endfunction

endpackage

// ----- sv/sfr_ifs.sv -----
`timescale 1ns / 1ps

// Received byte channel
interface sfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// Result channel
interface sfr_result_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic [7:0] payload_byte;
    logic       last;

    modport source (output valid, output status, output payload_byte, output last,
                    input ready);
    modport sink (input valid, input status, input payload_byte, input last,
                  output ready);
endinterface

// Length register write channel
interface sfr_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] payload_len;

    modport source (output valid, output payload_len, input ready);
    modport sink (input valid, input payload_len, output ready);
endinterface

// ----- sv/sfr_ram.sv -----
`timescale 1ns / 1ps

module sfr_ram #(
    parameter int DEPTH  = 32,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // One registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/sfr_cmd_fifo.sv -----
`timescale 1ns / 1ps

module sfr_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sfr_pkg::cmd_t push_cmd,
    input  logic          pop,
    output sfr_pkg::cmd_t pop_cmd,
    output logic          full,
    output logic          empty
);

    sfr_pkg::cmd_t                 mem [sfr_pkg::Q_DEPTH];
    logic [sfr_pkg::Q_PTR_W-1:0]   wr_ptr_reg;
    logic [sfr_pkg::Q_PTR_W-1:0]   wr_ptr_next;
    logic [sfr_pkg::Q_PTR_W-1:0]   rd_ptr_reg;
    logic [sfr_pkg::Q_PTR_W-1:0]   rd_ptr_next;
    logic [sfr_pkg::Q_CNT_W-1:0]   count_reg;
    logic [sfr_pkg::Q_CNT_W-1:0]   count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full    = (count_reg == sfr_pkg::Q_CNT_W'(sfr_pkg::Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = mem[rd_ptr_reg];

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- sv/sfr_front.sv -----
`timescale 1ns / 1ps

module sfr_front (
    input  logic                        clk,
    input  logic                        rst_n,
    sfr_byte_if.sink                    rx,
    sfr_cfg_if.sink                     cfg,
    input  sfr_pkg::back_stat_t         back_stat,
    input  logic                        q_full,
    input  logic                        q_empty,
    output logic                        q_push,
    output sfr_pkg::cmd_t               q_cmd,
    output logic                        wr_en,
    output logic [sfr_pkg::IDX_W-1:0]   wr_addr,
    output logic [7:0]                  wr_data
);

    logic [sfr_pkg::CFG_W-1:0]  len_cfg_reg;
    logic                       in_frame_reg;
    logic                       in_frame_next;
    logic [sfr_pkg::CNT_W-1:0]  cnt_reg;
    logic [sfr_pkg::CNT_W-1:0]  cnt_next;
    logic [7:0]                 sum_reg;
    logic [7:0]                 sum_next;
    logic [7:0]                 rsum_reg;
    logic [7:0]                 rsum_next;
    logic [sfr_pkg::LEN_W-1:0]  len;
    logic [sfr_pkg::CNT_W-1:0]  len_ext;
    logic                       is_pay;
    logic                       is_chk;
    logic                       is_tail;
    logic                       acc;

    // Length register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg <= sfr_pkg::LEN_RESET;
        end
        else if (cfg.valid)
        begin
            len_cfg_reg <= cfg.payload_len;
        end
    end

    // Classify the current position in the frame
    assign len     = sfr_pkg::eff_len(len_cfg_reg);
    assign len_ext = sfr_pkg::CNT_W'(len);
    assign is_pay  = in_frame_reg && (cnt_reg < len_ext);
    assign is_chk  = in_frame_reg && (cnt_reg == len_ext);
    assign is_tail = in_frame_reg && (cnt_reg > len_ext);

    // Payload bytes wait until no replay is pending or running; tail bytes wait for queue room
    assign rx.ready = !in_frame_reg || is_chk
                      || (is_pay && !back_stat.busy && q_empty)
                      || (is_tail && !q_full);
    assign acc = rx.valid && rx.ready;

    // Store write
    assign wr_en   = acc && is_pay;
    assign wr_addr = cnt_reg[sfr_pkg::IDX_W-1:0];
    assign wr_data = rx.rx_byte;

    // Closed frame command
    assign q_push     = acc && is_tail;
    assign q_cmd.len  = len;
    assign q_cmd.reject = !((rx.rx_byte == sfr_pkg::TAIL_BYTE) && (rsum_reg == sum_reg));

    // Parser state update
    always_comb
    begin
        in_frame_next = in_frame_reg;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        rsum_next     = rsum_reg;
        if (acc)
        begin
            if (!in_frame_reg)
            begin
                if (rx.rx_byte == sfr_pkg::HEADER_BYTE)
                begin
                    in_frame_next = 1'b1;
                    cnt_next      = '0;
                    sum_next      = '0;
                    rsum_next     = '0;
                end
            end
            else if (is_pay)
            begin
                sum_next = sum_reg + rx.rx_byte;
                cnt_next = cnt_reg + 1'b1;
            end
            else if (is_chk)
            begin
                rsum_next = rx.rx_byte;
                cnt_next  = cnt_reg + 1'b1;
            end
            else
            begin
                in_frame_next = 1'b0;
                cnt_next      = '0;
                sum_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            cnt_reg      <= '0;
            sum_reg      <= '0;
            rsum_reg     <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            cnt_reg      <= cnt_next;
            sum_reg      <= sum_next;
            rsum_reg     <= rsum_next;
        end
    end

`ifndef SYNTHESIS
    // Store is never overwritten while a replay may still read it
    a_wr_safe: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (!back_stat.busy && q_empty))
        else $error("store written during replay");

    // No command is dropped at the queue
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command pushed into full queue");

    // Tail beat always closes the frame
    a_tail_close: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> (!in_frame_reg && cnt_reg == '0))
        else $error("frame not closed after tail");
`endif

endmodule

// ----- sv/sfr_back.sv -----
`timescale 1ns / 1ps

module sfr_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  sfr_pkg::cmd_t               q_cmd,
    output logic                        q_pop,
    output sfr_pkg::back_stat_t         back_stat,
    output logic                        rd_en,
    output logic [sfr_pkg::IDX_W-1:0]   rd_addr,
    input  logic [7:0]                  rd_data,
    sfr_result_if.source                result
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;
    localparam logic [1:0] S_WAIT = 2'd3;

    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic [sfr_pkg::IDX_W-1:0]  idx_reg;
    logic [sfr_pkg::IDX_W-1:0]  idx_next;
    logic [sfr_pkg::LEN_W-1:0]  len_reg;
    logic [sfr_pkg::LEN_W-1:0]  len_next;
    logic                       status_reg;
    logic                       status_next;
    logic [7:0]                 byte_reg;
    logic [7:0]                 byte_next;
    logic                       last_reg;
    logic                       last_next;
    logic                       idx_is_last;

    assign idx_is_last = ((sfr_pkg::LEN_W'(idx_reg) + sfr_pkg::LEN_W'(1)) == len_reg);

    assign result.valid        = (state_reg == S_WAIT);
    assign result.status       = status_reg;
    assign result.payload_byte = byte_reg;
    assign result.last         = last_reg;

    assign back_stat.busy = (state_reg != S_IDLE);
    assign rd_addr        = idx_reg;

    // Replay sequencer
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        status_next = status_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        q_pop       = 1'b0;
        rd_en       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_cmd.reject)
                    begin
                        status_next = sfr_pkg::ST_REJECT;
                        byte_next   = '0;
                        last_next   = 1'b1;
                        state_next  = S_WAIT;
                    end
                    else
                    begin
                        idx_next   = '0;
                        len_next   = q_cmd.len;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                status_next = sfr_pkg::ST_PAYLOAD;
                byte_next   = rd_data;
                last_next   = idx_is_last;
                state_next  = S_WAIT;
            end
            S_WAIT:
            begin
                if (result.ready)
                begin
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        len_reg    <= len_next;
        status_reg <= status_next;
        byte_reg   <= byte_next;
        last_reg   <= last_next;
    end

`ifndef SYNTHESIS
    // Reject beat is a single zero beat closing the frame
    a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == sfr_pkg::ST_REJECT)
            |-> (result.payload_byte == '0 && result.last))
        else $error("malformed reject beat");

    // Commands leave the queue only when the sequencer is free
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE && !q_empty))
        else $error("pop while busy");

    // Store read is always followed by loading the result register
    a_read_load: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (state_reg == S_LOAD))
        else $error("read data not consumed");
`endif

endmodule

// ----- sv/serial_frame_receiver_sum_check.sv -----
`timescale 1ns / 1ps

// Channel   Role  Beat fields
// rx        sink  rx_byte[7:0]
// cfg       sink  payload_len[5:0]
// result    src   status, payload_byte[7:0], last
//
// Header and checksum bytes are never stalled; a tail byte waits for room in the queue.
// Replay of an accepted frame does a store read, result load and handshake per payload
// beat; a reject beat is shown in the cycle after its command is popped.
// Payload bytes of the next frame stall while a replay is pending or running.
// The result channel may stall at any time; one closed frame is held at a time.
// rst_n clears all control state asynchronously; payload_len resets to 4.

module serial_frame_receiver_sum_check (
    input  logic          clk,
    input  logic          rst_n,
    sfr_byte_if.sink      rx,
    sfr_cfg_if.sink       cfg,
    sfr_result_if.source  result
);

    sfr_pkg::back_stat_t          back_stat;
    sfr_pkg::cmd_t                push_cmd;
    sfr_pkg::cmd_t                pop_cmd;
    logic                         q_push;
    logic                         q_pop;
    logic                         q_full;
    logic                         q_empty;
    logic                         wr_en;
    logic [sfr_pkg::IDX_W-1:0]    wr_addr;
    logic [7:0]                   wr_data;
    logic                         rd_en;
    logic [sfr_pkg::IDX_W-1:0]    rd_addr;
    logic [7:0]                   rd_data;

    // Parser
    sfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .cfg       (cfg),
        .back_stat (back_stat),
        .q_full    (q_full),
        .q_empty   (q_empty),
        .q_push    (q_push),
        .q_cmd     (push_cmd),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // Frame store
    sfr_ram #(
        .DEPTH  (sfr_pkg::PAYLOAD_MAX),
        .WIDTH  (8),
        .ADDR_W (sfr_pkg::IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Closed frame queue
    sfr_cmd_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Replay
    sfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_cmd     (pop_cmd),
        .q_pop     (q_pop),
        .back_stat (back_stat),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .result    (result)
    );

endmodule

// ----- sim/serial_frame_receiver_sum_check_test.sv -----
`timescale 1ns / 1ps

module serial_frame_receiver_sum_check_test;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int LIMIT_CYCLES  = 500_000;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 31;

    // One result beat as seen on the result channel
    typedef struct packed {
        logic       status;
        logic [7:0] payload_byte;
        logic       last;
    } frame_beat_t;

    typedef enum logic [0:0] {
        ROW_BYTE,
        ROW_LEN
    } row_kind_t;

    // Directed row: a received byte or a length write, with an optional fixed result
    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  value;
        logic        typed;
        frame_beat_t beat;
    } script_row_t;

    localparam frame_beat_t NO_BEAT     = '{sfr_pkg::ST_PAYLOAD, 8'h00, 1'b0};
    localparam frame_beat_t REJECT_BEAT = '{sfr_pkg::ST_REJECT, 8'h00, 1'b1};
    localparam frame_beat_t SINGLE_FE   = '{sfr_pkg::ST_PAYLOAD, 8'hFE, 1'b1};

    localparam script_row_t SCRIPT [29] = '{
        // tail byte outside a frame is dropped
        '{ROW_BYTE, 8'h5A, 1'b0, NO_BEAT},
        // reset length 4: extremes and a header value as data, good frame
        '{ROW_BYTE, 8'hA5, 1'b0, NO_BEAT},
        '{ROW_BYTE, 8'hFF, 1'b0, NO_BEAT},
        '{ROW_BYTE, 8'h00, 1'b0, NO_BEAT},
        '{ROW_BYTE, 8'hA5, 1'b0, NO_BEAT},
        '{ROW_BYTE, 8'h80, 1'b0, NO_BEAT},
        '{ROW_BYTE, 8'h24, 1'b0, NO_BEAT},
        '{ROW_BYTE, 8'h5A, 1'b0, NO_BEAT},
        // zero length behaves as one
        '{ROW_LEN, 8'h00, 1'b0, NO_BEAT},
        // wrong tail
        '{ROW_BYTE, 8'hA5, 1'b0, NO_BEAT},
        '{ROW_BYTE, 8'h33, 1'b0, NO_BEAT},
        '{ROW_BYTE, 8'h33, 1'b0, NO_BEAT},
        '{ROW_BYTE, 8'h00, 1'b1, REJECT_BEAT},
        // wrong checksum
        '{ROW_BYTE, 8'hA5, 1'b0, NO_BEAT},
        '{ROW_BYTE, 8'h33, 1'b0, NO_BEAT},
        '{ROW_BYTE, 8'h34, 1'b0, NO_BEAT},
        '{ROW_BYTE, 8'h5A, 1'b1, REJECT_BEAT},
        // single byte frame accepted
        '{ROW_BYTE, 8'hA5, 1'b0, NO_BEAT},
        '{ROW_BYTE, 8'hFE, 1'b0, NO_BEAT},
        '{ROW_BYTE, 8'hFE, 1'b0, NO_BEAT},
        '{ROW_BYTE, 8'h5A, 1'b1, SINGLE_FE},
        // length raised in the middle of a frame
        '{ROW_LEN, 8'h02, 1'b0, NO_BEAT},
        '{ROW_BYTE, 8'hA5, 1'b0, NO_BEAT},
        '{ROW_BYTE, 8'h11, 1'b0, NO_BEAT},
        '{ROW_LEN, 8'h03, 1'b0, NO_BEAT},
        '{ROW_BYTE, 8'h22, 1'b0, NO_BEAT},
        '{ROW_BYTE, 8'h33, 1'b0, NO_BEAT},
        '{ROW_BYTE, 8'h66, 1'b0, NO_BEAT},
        '{ROW_BYTE, 8'h5A, 1'b0, NO_BEAT}
    };

    localparam logic [5:0] PHASE_LENS [PHASES] = '{
        6'd2, 6'd1, 6'd63, 6'd5, 6'd3, 6'd32, 6'd0, 6'd7, 6'd33, 6'd4
    };

    logic clk = 1'b0;
    logic rst_n;

    sfr_byte_if   rx_if ();
    sfr_cfg_if    cfg_if ();
    sfr_result_if res_if ();

    serial_frame_receiver_sum_check dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_if),
        .cfg    (cfg_if),
        .result (res_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Frame tracker state
    logic [5:0]  len_cfg;
    bit          open_frame;
    int          bytes_seen;
    logic [7:0]  payload_sum;
    logic [7:0]  sum_byte;
    logic [7:0]  frame_store [sfr_pkg::PAYLOAD_MAX];
    bit          store_valid [sfr_pkg::PAYLOAD_MAX];

    frame_beat_t pending_beats [$];
    int          mismatches;
    int          rx_items;
    bit          no_idle;
    bit          hold_req;

    // Payload bytes per frame for a length setting
    function automatic int frame_len(input logic [5:0] v);
        int n;
        n = int'(v);
        if (n == 0)
            n = 1;
        if (n > sfr_pkg::PAYLOAD_MAX)
            n = sfr_pkg::PAYLOAD_MAX;
        return n;
    endfunction

    // A new length must not make the replay read a store entry never written
    function automatic bit len_change_safe(input logic [5:0] v);
        int n;
        int lim;
        if (!open_frame)
            return 1'b1;
        n = frame_len(v);
        lim = (bytes_seen < n) ? bytes_seen : n;
        for (int i = 0; i < lim; i++)
        begin
            if (!store_valid[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advance the tracker by one byte; queue the beats a closing frame gives
    task automatic frame_step(input logic [7:0] b, input bit typed,
                              input frame_beat_t typed_beat);
        int n;
        frame_beat_t fb;
        n = frame_len(len_cfg);
        if (!open_frame)
        begin
            if (b == sfr_pkg::HEADER_BYTE)
            begin
                open_frame  = 1'b1;
                bytes_seen  = 0;
                payload_sum = 8'h00;
                sum_byte    = 8'h00;
            end
        end
        else if (bytes_seen < n)
        begin
            frame_store[bytes_seen] = b;
            store_valid[bytes_seen] = 1'b1;
            payload_sum = payload_sum + b;
            bytes_seen++;
        end
        else if (bytes_seen == n)
        begin
            sum_byte = b;
            bytes_seen++;
        end
        else
        begin
            // tail position closes the frame
            if (typed)
            begin
                pending_beats.push_back(typed_beat);
            end
            else if (b == sfr_pkg::TAIL_BYTE && sum_byte == payload_sum)
            begin
                for (int i = 0; i < n; i++)
                begin
                    fb.status       = sfr_pkg::ST_PAYLOAD;
                    fb.payload_byte = frame_store[i];
                    fb.last         = (i == n - 1);
                    pending_beats.push_back(fb);
                end
            end
            else
            begin
                pending_beats.push_back(REJECT_BEAT);
            end
            open_frame  = 1'b0;
            bytes_seen  = 0;
            payload_sum = 8'h00;
        end
    endtask

    // Offer one byte after a random gap and track it once accepted
    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input frame_beat_t typed_beat);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready) @(posedge clk);
        rx_items++;
        frame_step(b, typed, typed_beat);
    endtask

    // Stop offering, wait for every expected beat, then let the block go quiet
    task automatic settle_idle();
        rx_if.valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_len(input logic [5:0] v);
        cfg_if.valid       <= 1'b1;
        cfg_if.payload_len <= v;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
        len_cfg = v;
    endtask

    // Result sink: random stalls, one long hold on request, beat checks
    initial
    begin : result_sink
        int stall;
        frame_beat_t want;
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!res_if.valid) @(posedge clk);
            if (pending_beats.size() == 0)
            begin
                $error("unexpected result beat: status %0d payload_byte %02h last %0d",
                       res_if.status, res_if.payload_byte, res_if.last);
                mismatches++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (res_if.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, res_if.status);
                    mismatches++;
                end
                if (res_if.payload_byte !== want.payload_byte)
                begin
                    $error("payload_byte: expected %02h, actual %02h",
                           want.payload_byte, res_if.payload_byte);
                    mismatches++;
                end
                if (res_if.last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, res_if.last);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus: directed rows, then random phases of frames
    initial
    begin : stimulus
        logic [5:0] nlen;
        logic [7:0] b;
        logic [7:0] sum;
        int n;
        int pick;
        int cut;
        int stop_at;

        rst_n              <= 1'b0;
        rx_if.valid        <= 1'b0;
        rx_if.rx_byte      <= 8'h00;
        cfg_if.valid       <= 1'b0;
        cfg_if.payload_len <= 6'd0;
        mismatches  = 0;
        rx_items    = 0;
        no_idle     = 1'b0;
        hold_req    = 1'b0;
        len_cfg     = sfr_pkg::LEN_RESET;
        open_frame  = 1'b0;
        bytes_seen  = 0;
        payload_sum = 8'h00;
        sum_byte    = 8'h00;
        for (int i = 0; i < sfr_pkg::PAYLOAD_MAX; i++)
        begin
            frame_store[i] = 8'h00;
            store_valid[i] = 1'b0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (SCRIPT[r])
        begin
            if (SCRIPT[r].kind == ROW_LEN)
            begin
                settle_idle();
                write_len(SCRIPT[r].value[5:0]);
            end
            else
            begin
                send_byte(SCRIPT[r].value, SCRIPT[r].typed, SCRIPT[r].beat);
            end
        end

        // Random phases, one length setting each
        for (int p = 0; p < PHASES; p++)
        begin
            settle_idle();
            nlen = PHASE_LENS[p];
            if (!len_change_safe(nlen))
                nlen = len_cfg;
            write_len(nlen);
            no_idle = ((p % 4) == 3);
            // first phase: hold the result side while bytes keep coming
            if (p == 0)
                hold_req = 1'b1;
            stop_at = rx_items + PHASE_ITEMS;
            while (rx_items < stop_at)
            begin
                n = frame_len(len_cfg);
                pick = $urandom_range(0, 99);
                if (pick < 93)
                begin
                    send_byte(sfr_pkg::HEADER_BYTE, 1'b0, NO_BEAT);
                    sum = 8'h00;
                    // truncated frames stop somewhere in the payload
                    cut = (pick >= 86) ? $urandom_range(0, n) : n;
                    for (int i = 0; i < cut; i++)
                    begin
                        case ($urandom_range(0, 9))
                            0:       b = sfr_pkg::HEADER_BYTE;
                            1:       b = sfr_pkg::TAIL_BYTE;
                            default: b = 8'($urandom_range(0, 255));
                        endcase
                        sum = sum + b;
                        send_byte(b, 1'b0, NO_BEAT);
                    end
                    if (pick < 86)
                    begin
                        if (pick >= 70 && pick < 78)
                            sum = sum + 8'($urandom_range(1, 255));
                        send_byte(sum, 1'b0, NO_BEAT);
                        b = sfr_pkg::TAIL_BYTE;
                        if (pick >= 78)
                            b = sfr_pkg::TAIL_BYTE ^ 8'($urandom_range(1, 255));
                        send_byte(b, 1'b0, NO_BEAT);
                    end
                end
                else
                begin
                    // line noise
                    repeat ($urandom_range(1, 3))
                        send_byte(8'($urandom_range(0, 255)), 1'b0, NO_BEAT);
                end
            end
        end

        settle_idle();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Run limit
    initial
    begin : watchdog
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Some tests failed");
        $finish;
    end

endmodule
